>>> rtl/rpn_pkg.sv
// Shared constants and the controller-to-datapath command type for the
// running peak normalizer. No dependencies.
package rpn_pkg;

  localparam int unsigned BATCH_DEPTH = 64;
  localparam int unsigned FRAC_BITS   = 16;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned MAG_W    = SAMPLE_W - 1;
  localparam int unsigned RATIO_W  = FRAC_BITS + 1;
  localparam int unsigned IDX_W    = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(BATCH_DEPTH + 1);
  localparam int unsigned STEP_W   = $clog2(RATIO_W);

  localparam logic [RATIO_W-1:0] CLAMP_RESET = RATIO_W'((1 << FRAC_BITS) - 1);

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] wr_addr;
    logic             rd;
    logic [IDX_W-1:0] rd_addr;
    logic             div_step;
    logic             div_first;
    logic             div_last;
  } rpn_cmd_t;

endpackage

>>> rtl/rpn_ctrl.sv
// Controller: load phase, then per-result read and bit-serial divide sequence.
// Depends on rpn_pkg.
module rpn_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           batch_end_i,
  output logic           busy_o,
  output logic           valid_o,
  output logic           last_of_batch_o,
  output rpn_pkg::rpn_cmd_t cmd_o
);
  import rpn_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_DIV
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    fill_q;
  logic [CNT_W-1:0]    count_q;
  logic [IDX_W-1:0]    emit_idx_q;
  logic [STEP_W-1:0]   step_q;
  logic                valid_q;
  logic                last_q;

  logic                accept;
  logic [CNT_W-1:0]    fill_inc;
  logic                batch_done;
  logic                step_last;
  logic                emit_last;

  assign accept     = start_i && (state_q == ST_LOAD);
  assign fill_inc   = fill_q + CNT_W'(1);
  assign batch_done = batch_end_i || (fill_inc == CNT_W'(BATCH_DEPTH));
  assign step_last  = (step_q == STEP_W'(RATIO_W - 1));
  assign emit_last  = ((CNT_W'(emit_idx_q) + CNT_W'(1)) == count_q);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.wr_addr   = fill_q[IDX_W-1:0];
    cmd_o.rd        = (state_q == ST_READ);
    cmd_o.rd_addr   = emit_idx_q;
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.div_first = (step_q == '0);
    cmd_o.div_last  = step_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      fill_q     <= '0;
      count_q    <= '0;
      emit_idx_q <= '0;
      step_q     <= '0;
      valid_q    <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (batch_done) begin
              count_q    <= fill_inc;
              fill_q     <= '0;
              emit_idx_q <= '0;
              state_q    <= ST_READ;
            end else begin
              fill_q <= fill_inc;
            end
          end
        end
        ST_READ: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (step_last) begin
            valid_q <= 1'b1;
            last_q  <= emit_last;
            step_q  <= '0;
            if (emit_last) begin
              state_q <= ST_LOAD;
            end else begin
              emit_idx_q <= emit_idx_q + IDX_W'(1);
              state_q    <= ST_READ;
            end
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign busy_o          = (state_q != ST_LOAD);
  assign valid_o         = valid_q;
  assign last_of_batch_o = last_q;

endmodule

>>> rtl/rpn_datapath.sv
// Datapath: magnitude store, running peak, clamp register and a restoring
// divider that yields one quotient bit per cycle. Depends on rpn_pkg.
module rpn_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpn_pkg::rpn_cmd_t             cmd_i,
  input  logic [rpn_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                          clamp_we_i,
  input  logic [rpn_pkg::RATIO_W-1:0]   clamp_wdata_i,
  output logic [rpn_pkg::RATIO_W-1:0]   ratio_o
);
  import rpn_pkg::*;

  logic [MAG_W-1:0]   store_mem [BATCH_DEPTH];
  logic [MAG_W-1:0]   rdata_q;
  logic [MAG_W-1:0]   peak_q;
  logic [RATIO_W-1:0] clamp_q;
  logic [MAG_W:0]     rem_q;
  logic [RATIO_W-1:0] quot_q;
  logic [RATIO_W-1:0] ratio_q;

  logic [SAMPLE_W-1:0] neg;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W:0]      trial;
  logic                ge;
  logic [MAG_W:0]      rem_d;
  logic [RATIO_W-1:0]  quot_d;

  always_comb begin
    neg = ~sample_i + SAMPLE_W'(1);
    if (!sample_i[SAMPLE_W-1]) begin
      mag = sample_i[MAG_W-1:0];
    end else if (neg[SAMPLE_W-1]) begin
      mag = '1;
    end else begin
      mag = neg[MAG_W-1:0];
    end
  end

  always_comb begin
    trial  = cmd_i.div_first ? {1'b0, rdata_q} : {rem_q[MAG_W-1:0], 1'b0};
    ge     = (trial >= {1'b0, peak_q});
    rem_d  = ge ? (trial - {1'b0, peak_q}) : trial;
    quot_d = {quot_q[RATIO_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      store_mem[cmd_i.wr_addr] <= mag;
    end
    if (cmd_i.rd) begin
      rdata_q <= store_mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
      if (cmd_i.div_last) begin
        if (peak_q == '0) begin
          ratio_q <= '0;
        end else if (quot_d > clamp_q) begin
          ratio_q <= clamp_q;
        end else begin
          ratio_q <= quot_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      clamp_q <= CLAMP_RESET;
    end else begin
      if (clamp_we_i) begin
        clamp_q <= clamp_wdata_i;
      end
      if (cmd_i.load && (mag > peak_q)) begin
        peak_q <= mag;
      end
    end
  end

  assign ratio_o = ratio_q;

endmodule

>>> rtl/running_peak_normalizer_core.sv
// Running peak normalizer top level: controller plus datapath.
// Depends on rpn_pkg, rpn_ctrl and rpn_datapath.
//
// Usage:
//   Samples enter on sample_i/batch_end_i; a beat is taken at a clock edge
//   with start_i high and busy_o low, one beat per cycle while loading.
//   A beat with batch_end_i set, or the one that fills the 64-entry store,
//   closes the batch and busy_o rises. The block then emits one result per
//   stored sample in arrival order: ratio_o = min(mag * 2^16 / peak, clamp),
//   with peak the running maximum magnitude since reset (zero peak gives 0).
//   Each result is shown for one cycle with valid_o high; last_of_batch_o
//   marks the final one. The receiver cannot stall the block.
//   Each result takes one store read followed by the one-bit-per-cycle
//   restoring divider; busy_o falls with the last result.
//   clamp_limit is written through clamp_we_i/clamp_wdata_i; the user
//   must do so only while idle, which the block itself does not enforce.
//   Reset clears the running peak and fill count and sets the clamp to 65535;
//   the store needs no clearing.
module running_peak_normalizer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [rpn_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                          batch_end_i,
  output logic                          valid_o,
  output logic [rpn_pkg::RATIO_W-1:0]   ratio_o,
  output logic                          last_of_batch_o,
  input  logic                          clamp_we_i,
  input  logic [rpn_pkg::RATIO_W-1:0]   clamp_wdata_i
);
  import rpn_pkg::*;

  rpn_cmd_t cmd;

  rpn_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .batch_end_i     (batch_end_i),
    .busy_o          (busy_o),
    .valid_o         (valid_o),
    .last_of_batch_o (last_of_batch_o),
    .cmd_o           (cmd)
  );

  rpn_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sample_i      (sample_i),
    .clamp_we_i    (clamp_we_i),
    .clamp_wdata_i (clamp_wdata_i),
    .ratio_o       (ratio_o)
  );

endmodule

>>> rtl/rpn_checker.sv
// Port-level checks for running_peak_normalizer_core, bound to the top level.
// Depends only on the top level's handshake ports.
module rpn_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o,
  input logic last_of_batch_o
);

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result beat without a busy emit phase");

  a_results_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result beats back to back");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_of_batch_o) |-> !busy_o)
    else $error("still busy after last result");

  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_of_batch_o) |-> busy_o)
    else $error("idle before last result");

  a_busy_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy without an accepted sample");

endmodule

bind running_peak_normalizer_core rpn_checker u_rpn_checker (.*);
